### src/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the image tensor preprocessor
// Field widths, register indexes, command codes and the divider status type.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int MAX_SRC_DIM_DEF = 128;
  localparam int MAX_DST_DIM_DEF = 128;
  localparam int CHANNELS        = 3;

  localparam int PIX_W     = 8;
  localparam int COEF_W    = 20;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 16;
  localparam int COORD_W   = 7;
  localparam int DIM_W     = 8;
  localparam int OPT_W     = 2;
  localparam int CFG_W     = 60;
  localparam int CFG_IDX_W = 3;

  localparam int OPT_SWAP   = 0;
  localparam int OPT_PLANAR = 1;

  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_PRODUCE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_OPTIONS    = 3'd4,
    REG_GAINS      = 3'd5,
    REG_OFFSETS    = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### src/itp_coord_div.sv
// ----------------------------------------------------------------------------
// itp_coord_div: nearest-neighbour coordinate mapper
// Computes min(floor(out*src/dst), src-1) with a restoring divider that
// retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itp_coord_div #(
  parameter int SRC_W  = 8,
  parameter int DST_W  = 8,
  parameter int SIDX_W = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [itp_pkg::COORD_W-1:0]  out_coord,
  input  logic [SRC_W-1:0]             src,
  input  logic [DST_W-1:0]             dst,
  output itp_pkg::div_status_t         status,
  output logic [SIDX_W-1:0]            coord
);

  localparam int NUM_W = itp_pkg::COORD_W + SRC_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num;
  logic [DST_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DST_W:0]   rem_shift;
  logic             fits;
  logic [DST_W-1:0] rem_next;
  logic [SIDX_W-1:0] coord_next;

  always_comb begin
    rem_shift = {rem, num[NUM_W-1]};
    fits      = rem_shift >= {1'b0, dst};
    rem_next  = fits ? DST_W'(rem_shift - {1'b0, dst}) : DST_W'(rem_shift);
    // quotient has fully replaced the numerator once the count runs out
    coord_next = (num >= NUM_W'(src)) ? SIDX_W'(src - SRC_W'(1)) : SIDX_W'(num);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num  <= NUM_W'(out_coord) * NUM_W'(src);
        rem  <= '0;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != '0) begin
          rem <= rem_next;
          num <= {num[NUM_W-2:0], fits};
          cnt <= cnt - CNT_W'(1);
        end else begin
          coord <= coord_next;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

### src/itp_chan_lane.sv
// ----------------------------------------------------------------------------
// itp_chan_lane: one channel of the normalizer
// Registered pixel*gain product, offset add, and tensor index for the lane.
// ----------------------------------------------------------------------------
module itp_chan_lane #(
  parameter int LANE = 0
) (
  input  logic                             clk,
  input  logic                             load,
  input  logic [itp_pkg::PIX_W-1:0]        pixel,
  input  logic signed [itp_pkg::COEF_W-1:0] gain,
  input  logic signed [itp_pkg::COEF_W-1:0] offset,
  input  logic                             planar,
  input  logic [itp_pkg::IDX_W-1:0]        pos,
  input  logic [itp_pkg::IDX_W-1:0]        plane,
  output logic signed [itp_pkg::VAL_W-1:0] value,
  output logic [itp_pkg::IDX_W-1:0]        index
);

  localparam int PROD_W = itp_pkg::PIX_W + 1 + itp_pkg::COEF_W;
  localparam int SUM_W  = PROD_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= $signed({1'b0, pixel}) * gain;
    end
  end

  // |sum| stays below 2^28, so the Q15.16 result never reaches the clip points
  assign sum   = SUM_W'(prod) + SUM_W'(offset);
  assign value = itp_pkg::VAL_W'(sum);

  always_comb begin
    if (planar) begin
      index = itp_pkg::IDX_W'(itp_pkg::IDX_W'(LANE) * plane) + pos;
    end else begin
      index = itp_pkg::IDX_W'(pos * itp_pkg::IDX_W'(itp_pkg::CHANNELS))
            + itp_pkg::IDX_W'(LANE);
    end
  end

endmodule

### src/image_tensor_preprocess.sv
// ----------------------------------------------------------------------------
// image_tensor_preprocess: nearest-neighbour resize and per-channel normalize
// Frame store, coordinate mappers, three channel lanes and the output stage.
// ----------------------------------------------------------------------------
// A store command writes one pixel into the frame store and leaves the
// input ready for the next command. A produce command runs both coordinate
// mappers, one quotient bit per cycle, then reads the frame store and runs
// the three channel lanes; it holds the input until its result moves into
// the output register. A finished result sits in the output register, so
// the next command is taken while it waits. The frame store is not cleared:
// produce only pixels that have been stored.
module image_tensor_preprocess #(
  parameter int MAX_SRC_DIM = itp_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM = itp_pkg::MAX_DST_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [itp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [itp_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic [itp_pkg::COORD_W-1:0]        row,
  input  logic [itp_pkg::COORD_W-1:0]        col,
  input  logic [itp_pkg::PIX_W-1:0]          pixel_c0,
  input  logic [itp_pkg::PIX_W-1:0]          pixel_c1,
  input  logic [itp_pkg::PIX_W-1:0]          pixel_c2,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [itp_pkg::VAL_W-1:0]   value_c0,
  output logic signed [itp_pkg::VAL_W-1:0]   value_c1,
  output logic signed [itp_pkg::VAL_W-1:0]   value_c2,
  output logic [itp_pkg::IDX_W-1:0]          index_c0,
  output logic [itp_pkg::IDX_W-1:0]          index_c1,
  output logic [itp_pkg::IDX_W-1:0]          index_c2
);

  localparam int SRC_W  = $clog2(MAX_SRC_DIM + 1);
  localparam int DST_W  = $clog2(MAX_DST_DIM + 1);
  localparam int SIDX_W = $clog2(MAX_SRC_DIM);
  localparam int DEPTH  = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SCMP_W = (SRC_W > itp_pkg::DIM_W) ? SRC_W : itp_pkg::DIM_W;
  localparam int DCMP_W = (DST_W > itp_pkg::DIM_W) ? DST_W : itp_pkg::DIM_W;
  localparam int RCMP_W = (SRC_W > itp_pkg::COORD_W) ? SRC_W : itp_pkg::COORD_W;
  localparam int WORD_W = itp_pkg::PIX_W * itp_pkg::CHANNELS;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_READ, S_MUL} state_t;

  // configuration registers
  logic [itp_pkg::DIM_W-1:0]  src_width, src_height, dst_width, dst_height;
  logic [itp_pkg::OPT_W-1:0]  options;
  logic [itp_pkg::CFG_W-1:0]  gains_packed, offsets_packed;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width      <= itp_pkg::DIM_W'(128);
      src_height     <= itp_pkg::DIM_W'(128);
      dst_width      <= itp_pkg::DIM_W'(128);
      dst_height     <= itp_pkg::DIM_W'(128);
      options        <= '0;
      gains_packed   <= '0;
      offsets_packed <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        itp_pkg::REG_SRC_WIDTH:  src_width      <= cfg_data[itp_pkg::DIM_W-1:0];
        itp_pkg::REG_SRC_HEIGHT: src_height     <= cfg_data[itp_pkg::DIM_W-1:0];
        itp_pkg::REG_DST_WIDTH:  dst_width      <= cfg_data[itp_pkg::DIM_W-1:0];
        itp_pkg::REG_DST_HEIGHT: dst_height     <= cfg_data[itp_pkg::DIM_W-1:0];
        itp_pkg::REG_OPTIONS:    options        <= cfg_data[itp_pkg::OPT_W-1:0];
        itp_pkg::REG_GAINS:      gains_packed   <= cfg_data;
        itp_pkg::REG_OFFSETS:    offsets_packed <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize clips to the maximum
  logic [SCMP_W-1:0] sw_wide, sh_wide;
  logic [DCMP_W-1:0] dw_wide, dh_wide;
  logic [SRC_W-1:0]  sw_eff, sh_eff;
  logic [DST_W-1:0]  dw_eff, dh_eff;

  always_comb begin
    sw_wide = SCMP_W'(src_width);
    sh_wide = SCMP_W'(src_height);
    dw_wide = DCMP_W'(dst_width);
    dh_wide = DCMP_W'(dst_height);
    sw_eff = (sw_wide == '0) ? SRC_W'(1) :
             (sw_wide > SCMP_W'(MAX_SRC_DIM)) ? SRC_W'(MAX_SRC_DIM) : SRC_W'(sw_wide);
    sh_eff = (sh_wide == '0) ? SRC_W'(1) :
             (sh_wide > SCMP_W'(MAX_SRC_DIM)) ? SRC_W'(MAX_SRC_DIM) : SRC_W'(sh_wide);
    dw_eff = (dw_wide == '0) ? DST_W'(1) :
             (dw_wide > DCMP_W'(MAX_DST_DIM)) ? DST_W'(MAX_DST_DIM) : DST_W'(dw_wide);
    dh_eff = (dh_wide == '0) ? DST_W'(1) :
             (dh_wide > DCMP_W'(MAX_DST_DIM)) ? DST_W'(MAX_DST_DIM) : DST_W'(dh_wide);
  end

  state_t state;

  logic in_xfer, start, st_we, st_in_range, rd_en, out_load;
  logic [ADDR_W-1:0] st_addr, rd_addr;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign start    = in_xfer && (command == itp_pkg::CMD_PRODUCE);
  assign st_in_range = (RCMP_W'(row) < RCMP_W'(MAX_SRC_DIM)) &&
                       (RCMP_W'(col) < RCMP_W'(MAX_SRC_DIM));
  assign st_we    = in_xfer && (command == itp_pkg::CMD_STORE) && st_in_range;
  assign st_addr  = ADDR_W'(ADDR_W'(SIDX_W'(row)) * ADDR_W'(MAX_SRC_DIM))
                  + ADDR_W'(SIDX_W'(col));

  // coordinate mappers
  itp_pkg::div_status_t row_st, col_st;
  logic [SIDX_W-1:0]    src_row, src_col;

  itp_coord_div #(.SRC_W(SRC_W), .DST_W(DST_W), .SIDX_W(SIDX_W)) u_row_div (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .out_coord (row),
    .src       (sh_eff),
    .dst       (dh_eff),
    .status    (row_st),
    .coord     (src_row)
  );

  itp_coord_div #(.SRC_W(SRC_W), .DST_W(DST_W), .SIDX_W(SIDX_W)) u_col_div (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .out_coord (col),
    .src       (sw_eff),
    .dst       (dw_eff),
    .status    (col_st),
    .coord     (src_col)
  );

  assign rd_en   = (state == S_DIV) && row_st.done && col_st.done;
  assign rd_addr = ADDR_W'(ADDR_W'(src_row) * ADDR_W'(MAX_SRC_DIM)) + ADDR_W'(src_col);

  // frame store
  logic [WORD_W-1:0] frame_store [DEPTH];
  logic [WORD_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (st_we) begin
      frame_store[st_addr] <= {pixel_c2, pixel_c1, pixel_c0};
    end
    if (rd_en) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  // tensor position terms, settled long before the lanes need them
  logic [itp_pkg::COORD_W-1:0] row_q, col_q;
  logic [itp_pkg::IDX_W-1:0]   pos, plane;

  always_ff @(posedge clk) begin
    if (start) begin
      row_q <= row;
      col_q <= col;
    end
    pos   <= itp_pkg::IDX_W'(itp_pkg::IDX_W'(row_q) * itp_pkg::IDX_W'(dw_eff))
           + itp_pkg::IDX_W'(col_q);
    plane <= itp_pkg::IDX_W'(itp_pkg::IDX_W'(dh_eff) * itp_pkg::IDX_W'(dw_eff));
  end

  // channel lanes
  logic [itp_pkg::PIX_W-1:0]         lane_pix   [itp_pkg::CHANNELS];
  logic signed [itp_pkg::VAL_W-1:0]  lane_value [itp_pkg::CHANNELS];
  logic [itp_pkg::IDX_W-1:0]         lane_index [itp_pkg::CHANNELS];

  always_comb begin
    lane_pix[0] = options[itp_pkg::OPT_SWAP] ? rd_data[23:16] : rd_data[7:0];
    lane_pix[1] = rd_data[15:8];
    lane_pix[2] = options[itp_pkg::OPT_SWAP] ? rd_data[7:0] : rd_data[23:16];
  end

  for (genvar c = 0; c < itp_pkg::CHANNELS; c++) begin : g_lane
    itp_chan_lane #(.LANE(c)) u_lane (
      .clk    (clk),
      .load   (state == S_READ),
      .pixel  (lane_pix[c]),
      .gain   ($signed(gains_packed[c*itp_pkg::COEF_W +: itp_pkg::COEF_W])),
      .offset ($signed(offsets_packed[c*itp_pkg::COEF_W +: itp_pkg::COEF_W])),
      .planar (options[itp_pkg::OPT_PLANAR]),
      .pos    (pos),
      .plane  (plane),
      .value  (lane_value[c]),
      .index  (lane_index[c])
    );
  end

  // result moves into the output register once it is empty or being drained
  assign out_load = (state == S_MUL) && (!out_valid || out_ready);

  // control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rd_en) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_MUL;
        end
        S_MUL: begin
          // hold the result in the lanes until the output register frees up
          if (out_load) begin
            value_c0  <= lane_value[0];
            value_c1  <= lane_value[1];
            value_c2  <= lane_value[2];
            index_c0  <= lane_index[0];
            index_c1  <= lane_index[1];
            index_c2  <= lane_index[2];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // both mappers are started together and take the same number of cycles
  assert property (@(posedge clk) disable iff (rst)
    (row_st.done == col_st.done) && (row_st.busy == col_st.busy))
    else $error("coordinate mappers out of step");

  assert property (@(posedge clk) disable iff (rst)
    row_st.busy |-> (state == S_DIV))
    else $error("mapper busy outside the divide phase");

  assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("input taken again right after a produce transfer");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && out_valid && !out_ready) |=> (state == S_MUL))
    else $error("result dropped while the output register was full");

endmodule

### verif/image_tensor_preprocess_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_tensor_preprocess_tb: self-checking bench for the resize/normalize block
// Stores source pixels, then requests output pixels under a series of register
// settings. Each produce transfer is predicted in the bench and each result is
// checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module image_tensor_preprocess_tb;
  import itp_pkg::*;

  localparam int MAX_SRC         = MAX_SRC_DIM_DEF;
  localparam int MAX_DST         = MAX_DST_DIM_DEF;
  localparam int STORE_DEPTH     = MAX_SRC * MAX_SRC;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int DRAIN_CYCLES    = 48;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [CHANNELS-1:0][VAL_W-1:0] value;
    logic [CHANNELS-1:0][IDX_W-1:0] index;
  } tensor_px_t;

  // Shadow of the block: registers, frame store and outstanding output pixels.
  class tensor_scoreboard;
    bit [DIM_W-1:0] src_w, src_h, dst_w, dst_h;
    bit [OPT_W-1:0] opts;
    bit [CFG_W-1:0] gains, offsets;
    bit [3*PIX_W-1:0] pixels [STORE_DEPTH];
    tensor_px_t outstanding_q[$];
    int errors;
    int checked;

    function new();
      src_w = 8'd128;
      src_h = 8'd128;
      dst_w = 8'd128;
      dst_h = 8'd128;
      opts = '0;
      gains = '0;
      offsets = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SRC_WIDTH:  src_w = data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_h = data[DIM_W-1:0];
        REG_DST_WIDTH:  dst_w = data[DIM_W-1:0];
        REG_DST_HEIGHT: dst_h = data[DIM_W-1:0];
        REG_OPTIONS:    opts = data[OPT_W-1:0];
        REG_GAINS:      gains = data;
        REG_OFFSETS:    offsets = data;
        default: ;
      endcase
    endfunction

    // zero acts as one, oversize acts as the maximum
    function int eff_dim(bit [DIM_W-1:0] v, int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : int'(v);
    endfunction

    function int nearest(int o, int s, int d);
      int q;
      q = (o * s) / d;
      return (q >= s) ? s - 1 : q;
    endfunction

    function int source_addr(int r, int c);
      return nearest(r, eff_dim(src_h, MAX_SRC), eff_dim(dst_h, MAX_DST)) * MAX_SRC
           + nearest(c, eff_dim(src_w, MAX_SRC), eff_dim(dst_w, MAX_DST));
    endfunction

    function void note_input(logic cmd, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                             logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                             logic [PIX_W-1:0] p2);
      tensor_px_t e;
      bit [PIX_W-1:0] px [CHANNELS];
      bit [3*PIX_W-1:0] word;
      bit [PIX_W-1:0] t;
      logic signed [COEF_W-1:0] g, k;
      longint acc;
      int dw, dh, pos;
      if (cmd == CMD_STORE) begin
        pixels[r * MAX_SRC + c] = {p2, p1, p0};
        return;
      end
      word = pixels[source_addr(r, c)];
      px[0] = word[7:0];
      px[1] = word[15:8];
      px[2] = word[23:16];
      if (opts[OPT_SWAP]) begin
        t = px[0];
        px[0] = px[2];
        px[2] = t;
      end
      dw = eff_dim(dst_w, MAX_DST);
      dh = eff_dim(dst_h, MAX_DST);
      pos = r * dw + c;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        g = gains[COEF_W*ch +: COEF_W];
        k = offsets[COEF_W*ch +: COEF_W];
        acc = longint'(px[ch]) * longint'(g) + longint'(k);
        if (acc > SAT_MAX) acc = SAT_MAX;
        if (acc < SAT_MIN) acc = SAT_MIN;
        e.value[ch] = acc[VAL_W-1:0];
        e.index[ch] = opts[OPT_PLANAR] ? IDX_W'(ch * dh * dw + pos) : IDX_W'(pos * 3 + ch);
      end
      outstanding_q.push_back(e);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void check_result(tensor_px_t got);
      tensor_px_t e;
      if (outstanding_q.size() == 0) begin
        flag("output transfer with no pixel outstanding");
        return;
      end
      e = outstanding_q.pop_front();
      checked++;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (got.value[ch] !== e.value[ch])
          flag($sformatf("result %0d value_c%0d exp %0d got %0d", checked, ch,
                         $signed(e.value[ch]), $signed(got.value[ch])));
        if (got.index[ch] !== e.index[ch])
          flag($sformatf("result %0d index_c%0d exp %0d got %0d", checked, ch,
                         e.index[ch], got.index[ch]));
      end
    endfunction

    function int pending();
      return outstanding_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  command = CMD_STORE;
  logic [COORD_W-1:0]    row = '0;
  logic [COORD_W-1:0]    col = '0;
  logic [PIX_W-1:0]      pixel_c0 = '0;
  logic [PIX_W-1:0]      pixel_c1 = '0;
  logic [PIX_W-1:0]      pixel_c2 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [VAL_W-1:0] value_c0, value_c1, value_c2;
  logic [IDX_W-1:0]      index_c0, index_c1, index_c2;

  tensor_scoreboard sb = new();
  bit stored_map [STORE_DEPTH];
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int n_stores, n_produces, n_settings;
  int idle_cycles;

  image_tensor_preprocess u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .row       (row),
    .col       (col),
    .pixel_c0  (pixel_c0),
    .pixel_c1  (pixel_c1),
    .pixel_c2  (pixel_c2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_c0  (value_c0),
    .value_c1  (value_c1),
    .value_c2  (value_c2),
    .index_c0  (index_c0),
    .index_c1  (index_c1),
    .index_c2  (index_c2)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    tensor_px_t seen;
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_input(command, row, col, pixel_c0, pixel_c1, pixel_c2);
      if (out_valid && out_ready) begin
        seen.value = {value_c2, value_c1, value_c0};
        seen.index = {index_c2, index_c1, index_c0};
        sb.check_result(seen);
      end
    end
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d pixels outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("image_tensor_preprocess regression: fail");
        $finish;
      end
    end
  end

  // output side: random backpressure, one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = quiet || ($urandom_range(99) >= 15);
    end
  end

  task automatic send_item(logic cmd, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                           logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                           logic [PIX_W-1:0] p2);
    int gap;
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    command = cmd;
    row = r;
    col = c;
    pixel_c0 = p0;
    pixel_c1 = p1;
    pixel_c2 = p2;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic store_at(int r, int c, logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                          logic [PIX_W-1:0] p2);
    stored_map[r * MAX_SRC + c] = 1'b1;
    n_stores++;
    send_item(CMD_STORE, COORD_W'(r), COORD_W'(c), p0, p1, p2);
  endtask

  // never read an unwritten frame-store entry: fill the mapped source first
  task automatic produce_at(int r, int c);
    int addr;
    addr = sb.source_addr(r, c);
    if (!stored_map[addr])
      store_at(addr / MAX_SRC, addr % MAX_SRC, PIX_W'($urandom), PIX_W'($urandom),
               PIX_W'($urandom));
    n_produces++;
    send_item(CMD_PRODUCE, COORD_W'(r), COORD_W'(c), PIX_W'($urandom), PIX_W'($urandom),
              PIX_W'($urandom));
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_write = 1'b1;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(int sw, int sh, int dw, int dh, int opt,
                           logic [CFG_W-1:0] g, logic [CFG_W-1:0] o);
    write_cfg(REG_SRC_WIDTH, CFG_W'(sw));
    write_cfg(REG_SRC_HEIGHT, CFG_W'(sh));
    write_cfg(REG_DST_WIDTH, CFG_W'(dw));
    write_cfg(REG_DST_HEIGHT, CFG_W'(dh));
    write_cfg(REG_OPTIONS, CFG_W'(opt));
    write_cfg(REG_GAINS, g);
    write_cfg(REG_OFFSETS, o);
    cfg_write = 1'b0;
    n_settings++;
  endtask

  function automatic logic [CFG_W-1:0] rand_coefs(int mode);
    case (mode)
      1:       return {3{20'h7FFFF}};
      2:       return {3{20'h80000}};
      default: return CFG_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic random_item();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) begin
      if ($urandom_range(1))
        store_at($urandom_range(MAX_SRC - 1), $urandom_range(MAX_SRC - 1),
                 PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
      else
        store_at($urandom_range(sb.eff_dim(sb.src_h, MAX_SRC) - 1),
                 $urandom_range(sb.eff_dim(sb.src_w, MAX_SRC) - 1),
                 PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
    end else if (roll < 80) begin
      produce_at($urandom_range(sb.eff_dim(sb.dst_h, MAX_DST) - 1),
                 $urandom_range(sb.eff_dim(sb.dst_w, MAX_DST) - 1));
    end else begin
      // positions past the output size clamp to the last source row or column
      produce_at($urandom_range((1 << COORD_W) - 1), $urandom_range((1 << COORD_W) - 1));
    end
  endtask

  initial begin
    int sw, sh, dw, dh;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed: coefficient extremes, 2x2 source upscaled to 3x3
    configure(2, 2, 3, 3, 0, {20'h10000, 20'h80000, 20'h7FFFF},
              {20'h00000, 20'h80000, 20'h7FFFF});
    store_at(0, 0, 8'h00, 8'h00, 8'h00);
    store_at(0, 1, 8'hFF, 8'hFF, 8'hFF);
    store_at(1, 0, 8'h12, 8'h34, 8'h56);
    store_at(1, 1, 8'hFF, 8'h00, 8'hAA);
    store_at(127, 127, 8'hAB, 8'hCD, 8'hEF);
    produce_at(0, 0);
    produce_at(0, 1);
    produce_at(0, 2);
    produce_at(1, 1);
    produce_at(2, 2);
    produce_at(127, 127);
    produce_at(127, 0);
    wait_idle();
    // swap + planar, and a write to an index past the register list
    write_cfg(REG_OPTIONS, CFG_W'(2'd3));
    write_cfg(REG_UNUSED, '1);
    cfg_write = 1'b0;
    produce_at(0, 2);
    produce_at(2, 0);
    produce_at(1, 2);
    wait_idle();
    // zero and oversize size registers
    configure(0, 200, 255, 0, 1, rand_coefs(0), rand_coefs(0));
    produce_at(0, 0);
    produce_at(5, 100);
    produce_at(127, 127);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin sw = 128; sh = 128; dw = 128; dh = 128; end
        1: begin sw = 1; sh = 1; dw = 1; dh = 1; end
        7: begin
          sw = $urandom_range(129, 255);
          sh = 0;
          dw = 0;
          dh = $urandom_range(129, 255);
        end
        default: begin
          sw = $urandom_range(1, (ph == 4) ? 128 : 12);
          sh = $urandom_range(1, (ph == 4) ? 128 : 12);
          dw = $urandom_range(1, (ph == 4) ? 128 : 24);
          dh = $urandom_range(1, (ph == 4) ? 128 : 24);
        end
      endcase
      configure(sw, sh, dw, dh, ph % 4, rand_coefs((ph == 1) ? 1 : (ph == 2) ? 2 : 0),
                rand_coefs((ph == 2) ? 1 : (ph == 1) ? 2 : 0));
      quiet = (ph == 6);
      if (ph == 3) begin
        // output stalls long enough for the block to back up its input
        hold_req = 1'b1;
        repeat (12) produce_at($urandom_range(sb.eff_dim(sb.dst_h, MAX_DST) - 1),
                               $urandom_range(sb.eff_dim(sb.dst_w, MAX_DST) - 1));
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 5 && i == ITEMS_PER_PHASE / 2) begin
          in_valid = 1'b0;
          while (sb.pending() != 0) @(negedge clk);
        end
        random_item();
      end
    end
    quiet = 1'b0;
    wait_idle();

    $display("covered %0d pixel stores and %0d output pixels under %0d register settings",
             n_stores, n_produces, n_settings);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("image_tensor_preprocess regression: pass");
    end else begin
      $display("image_tensor_preprocess regression: fail");
    end
    $finish;
  end

endmodule
